// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the format argument typer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset disable
`define PFAT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion on the block clock and reset
`define PFAT_ASSERT(label, prop, msg) \
    `PFAT_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== design/pfat_pkg.sv =====
// ----------------------------------------------------------------------------
// pfat_pkg
// Shared types and constants of the printf format argument typer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfat_pkg;

    // Result kinds (travel on m_tuser)
    typedef enum logic [1:0] {
        KIND_DESC    = 2'd0,
        KIND_VALID   = 2'd1,
        KIND_INVALID = 2'd2
    } kind_t;

    // Argument type classes
    typedef enum logic [2:0] {
        CLS_INT      = 3'd0,
        CLS_FLOAT    = 3'd1,
        CLS_PTR_INT  = 3'd2,
        CLS_PTR_CHAR = 3'd3,
        CLS_PTR_WIDE = 3'd4,
        CLS_PTR_VOID = 3'd5
    } cls_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_ADDR_SIZE = 2'd0;
    localparam logic [1:0] CFG_FAMILY    = 2'd1;

    // Platform family codes
    localparam logic [1:0] FAM_WINDOWS = 2'd1;
    localparam logic [1:0] FAM_APPLE   = 2'd2;

    // Reset value of the pointer size register
    localparam logic [3:0] ADDR_SIZE_RESET = 4'd8;

    // Slots of a job's item mask, in emission order
    localparam int JOB_WSTAR = 0;
    localparam int JOB_PSTAR = 1;
    localparam int JOB_DESC  = 2;
    localparam int JOB_TERM  = 3;
    localparam int JOB_SLOTS = 4;

    // Byte width of an int argument consumed by a '*'
    localparam logic [4:0] STAR_WIDTH = 5'd4;

    // Output tdata width (15 payload bits padded to two bytes)
    localparam int TDATA_W = 16;

    typedef struct packed {
        cls_t       cls;
        logic [4:0] vw;
        logic [3:0] pw;
        logic       sg;
        logic       unc;
        logic       heu;
    } desc_t;

    // One classified character: which results it causes and their contents
    typedef struct packed {
        logic [JOB_SLOTS-1:0] mask;
        kind_t                term_kind;
        desc_t                desc;
    } job_t;

endpackage

// ===== design/pfat_queue.sv =====
// ----------------------------------------------------------------------------
// pfat_queue
// Small job queue between the classifier front and the emitter back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfat_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pfat_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output pfat_pkg::job_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfat_pkg::job_t   store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = store[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== design/pfat_front.sv =====
// ----------------------------------------------------------------------------
// pfat_front
// Format string parser: walks the specification phases one character per
// cycle unless the queue is full, checks each conversion, queues its results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfat_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,     // [7:0] text_char
    input  logic            s_tlast,     // end_of_string
    input  logic [3:0]      addr_size,
    input  logic [1:0]      family,
    input  logic            queue_full,
    output logic            push,
    output pfat_pkg::job_t  push_job
);

    typedef enum logic [3:0] {
        PH_PLAIN, PH_FLAGS, PH_WIDTH, PH_PREC_DOT, PH_PREC_START,
        PH_PREC_DIG, PH_LEN, PH_AFTER_H, PH_AFTER_L, PH_CONV
    } phase_t;

    typedef enum logic [3:0] {
        LEN_NONE, LEN_HH, LEN_H, LEN_L, LEN_LL, LEN_J, LEN_Z, LEN_T, LEN_CAPL
    } len_t;

    typedef enum logic [3:0] {
        CV_SINT, CV_OXX, CV_U, CV_FLT, CV_CHR, CV_STR, CV_PTR, CV_CNT, CV_PCT, CV_BAD
    } conv_t;

    localparam logic [7:0] CH_PERCENT = "%";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_DOT     = ".";

    // Flag bit positions
    localparam int FL_MINUS = 0;
    localparam int FL_PLUS  = 1;
    localparam int FL_SPACE = 2;
    localparam int FL_HASH  = 3;
    localparam int FL_ZERO  = 4;

    phase_t     phase_reg;
    logic [4:0] flags_reg;
    logic       wgiven_reg, wstar_reg, pgiven_reg, pstar_reg, failed_reg;
    len_t       len_reg;

    phase_t     ph;
    logic [4:0] fl;
    logic       wg, ws, pg, ps, fail;
    len_t       ln;
    logic       handled, conv_hit, is_digit, accept;

    conv_t           cv;
    logic            is_win, is_apple, a_zero;
    logic [3:0]      iw;
    logic [4:0]      w;
    logic            flags_ok, len_ok, wp_ok, desc_ok, has_desc;
    pfat_pkg::desc_t d;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= "0") && (s_tdata <= "9");
    assign is_win   = (family == pfat_pkg::FAM_WINDOWS);
    assign is_apple = (family == pfat_pkg::FAM_APPLE);
    assign a_zero   = (addr_size == 4'd0);

    // Phase walk for one character
    always_comb begin
        ph       = phase_reg;
        fl       = flags_reg;
        wg       = wgiven_reg;
        ws       = wstar_reg;
        pg       = pgiven_reg;
        ps       = pstar_reg;
        ln       = len_reg;
        handled  = 1'b0;
        conv_hit = 1'b0;
        if (!failed_reg) begin
            if (ph == PH_PLAIN) begin
                handled = 1'b1;
                if (s_tdata == CH_PERCENT) begin
                    ph = PH_FLAGS;
                    fl = '0;
                    wg = 1'b0;
                    ws = 1'b0;
                    pg = 1'b0;
                    ps = 1'b0;
                    ln = LEN_NONE;
                end
            end
            if (!handled && ph == PH_FLAGS) begin
                handled = 1'b1;
                case (s_tdata)
                    "-": fl[FL_MINUS] = 1'b1;
                    "+": fl[FL_PLUS]  = 1'b1;
                    " ": fl[FL_SPACE] = 1'b1;
                    "#": fl[FL_HASH]  = 1'b1;
                    "0": fl[FL_ZERO]  = 1'b1;
                    CH_STAR: begin
                        wg = 1'b1;
                        ws = 1'b1;
                        ph = PH_PREC_DOT;
                    end
                    default: begin
                        handled = 1'b0;
                        ph      = PH_WIDTH;
                    end
                endcase
            end
            if (!handled && ph == PH_WIDTH) begin
                if (is_digit) begin
                    wg      = 1'b1;
                    handled = 1'b1;
                end else begin
                    ph = PH_PREC_DOT;
                end
            end
            if (!handled && ph == PH_PREC_DOT) begin
                if (s_tdata == CH_DOT) begin
                    pg      = 1'b1;
                    ph      = PH_PREC_START;
                    handled = 1'b1;
                end else begin
                    ph = PH_LEN;
                end
            end
            if (!handled && ph == PH_PREC_START) begin
                if (s_tdata == CH_STAR) begin
                    ps      = 1'b1;
                    ph      = PH_LEN;
                    handled = 1'b1;
                end else begin
                    ph = PH_PREC_DIG;
                end
            end
            if (!handled && ph == PH_PREC_DIG) begin
                if (is_digit) begin
                    handled = 1'b1;
                end else begin
                    ph = PH_LEN;
                end
            end
            if (!handled && ph == PH_LEN) begin
                handled = 1'b1;
                case (s_tdata)
                    "h": begin ln = LEN_H;    ph = PH_AFTER_H; end
                    "l": begin ln = LEN_L;    ph = PH_AFTER_L; end
                    "j": begin ln = LEN_J;    ph = PH_CONV;    end
                    "z": begin ln = LEN_Z;    ph = PH_CONV;    end
                    "t": begin ln = LEN_T;    ph = PH_CONV;    end
                    "L": begin ln = LEN_CAPL; ph = PH_CONV;    end
                    default: begin
                        handled = 1'b0;
                        ph      = PH_CONV;
                    end
                endcase
            end
            if (!handled && ph == PH_AFTER_H) begin
                ph = PH_CONV;
                if (s_tdata == "h") begin
                    ln      = LEN_HH;
                    handled = 1'b1;
                end
            end
            if (!handled && ph == PH_AFTER_L) begin
                ph = PH_CONV;
                if (s_tdata == "l") begin
                    ln      = LEN_LL;
                    handled = 1'b1;
                end
            end
            // Anything still unhandled is the conversion character
            if (!handled) begin
                ph       = PH_PLAIN;
                conv_hit = 1'b1;
            end
        end
    end

    // Conversion character decode
    always_comb begin
        unique case (s_tdata) inside
            "d", "i":                               cv = CV_SINT;
            "o", "x", "X":                          cv = CV_OXX;
            "u":                                    cv = CV_U;
            "f", "F", "e", "E", "g", "G", "a", "A": cv = CV_FLT;
            "c":                                    cv = CV_CHR;
            "s":                                    cv = CV_STR;
            "p":                                    cv = CV_PTR;
            "n":                                    cv = CV_CNT;
            CH_PERCENT:                             cv = CV_PCT;
            default:                                cv = CV_BAD;
        endcase
    end

    // Integer width for the current length modifier; zero when unavailable
    always_comb begin
        case (ln)
            LEN_NONE:        iw = 4'd4;
            LEN_HH:          iw = 4'd1;
            LEN_H:           iw = 4'd2;
            LEN_L:           iw = a_zero ? 4'd0 : (is_win ? 4'd4 : addr_size);
            LEN_LL, LEN_J:   iw = 4'd8;
            LEN_Z, LEN_T:    iw = addr_size;
            default:         iw = 4'd0;
        endcase
    end

    // Legality checks and descriptor per conversion
    always_comb begin
        flags_ok = 1'b0;
        len_ok   = 1'b0;
        wp_ok    = 1'b1;
        desc_ok  = 1'b1;
        has_desc = 1'b1;
        w        = {1'b0, iw};
        d        = '{cls: pfat_pkg::CLS_INT, vw: 5'd4, pw: 4'd0, sg: 1'b1, unc: 1'b0,
                     heu: 1'b0};
        case (cv)
            CV_SINT, CV_OXX, CV_U: begin
                len_ok = (ln <= LEN_T);
                if (cv == CV_SINT) begin
                    flags_ok = !fl[FL_HASH];
                end else if (cv == CV_OXX) begin
                    flags_ok = !fl[FL_PLUS] && !fl[FL_SPACE];
                end else begin
                    flags_ok = !fl[FL_PLUS] && !fl[FL_SPACE] && !fl[FL_HASH];
                end
                if (ln == LEN_HH || ln == LEN_H) begin
                    // Promoted short types: signed int, guessed for unsigned forms
                    d.unc = (cv != CV_SINT);
                    d.heu = (cv != CV_SINT);
                end else begin
                    desc_ok = (iw != 4'd0);
                    d.vw    = w;
                    d.sg    = (cv == CV_SINT);
                end
            end
            CV_FLT: begin
                flags_ok = 1'b1;
                len_ok   = (ln == LEN_NONE) || (ln == LEN_L) || (ln == LEN_CAPL);
                d.cls    = pfat_pkg::CLS_FLOAT;
                d.sg     = 1'b0;
                d.vw     = 5'd8;
                if (ln == LEN_CAPL) begin
                    desc_ok = !a_zero;
                    if (!is_win && !is_apple) begin
                        d.vw = (addr_size == 4'd4) ? 5'd12 : 5'd16;
                    end
                end
            end
            CV_CHR: begin
                flags_ok = (fl[4:1] == '0);
                len_ok   = (ln == LEN_NONE) || (ln == LEN_L);
                wp_ok    = !pg;
                d.unc    = (ln == LEN_L);
                d.heu    = (ln == LEN_L);
            end
            CV_STR: begin
                flags_ok = (fl[4:1] == '0);
                len_ok   = (ln == LEN_NONE) || (ln == LEN_L);
                desc_ok  = !a_zero;
                d.pw     = addr_size;
                if (ln == LEN_L) begin
                    d.cls = pfat_pkg::CLS_PTR_WIDE;
                    d.vw  = is_win ? 5'd2 : 5'd4;
                    d.sg  = 1'b0;
                end else begin
                    d.cls = pfat_pkg::CLS_PTR_CHAR;
                    d.vw  = 5'd1;
                    d.unc = 1'b1;
                end
            end
            CV_PTR: begin
                flags_ok = (fl[4:1] == '0);
                len_ok   = (ln == LEN_NONE);
                wp_ok    = !pg;
                desc_ok  = !a_zero;
                d.cls    = pfat_pkg::CLS_PTR_VOID;
                d.vw     = 5'd0;
                d.sg     = 1'b0;
                d.pw     = addr_size;
            end
            CV_CNT: begin
                flags_ok = (fl == '0);
                len_ok   = (ln <= LEN_T);
                wp_ok    = !wg && !pg;
                desc_ok  = (iw != 4'd0) && !a_zero;
                d.cls    = pfat_pkg::CLS_PTR_INT;
                d.vw     = w;
                d.pw     = addr_size;
            end
            CV_PCT: begin
                flags_ok = (fl == '0);
                len_ok   = (ln == LEN_NONE);
                wp_ok    = !wg && !pg;
                has_desc = 1'b0;
            end
            default: begin
                desc_ok  = 1'b0;
            end
        endcase
    end

    // Job assembly and end-of-string verdict
    always_comb begin
        fail               = failed_reg;
        push_job.mask      = '0;
        push_job.term_kind = pfat_pkg::KIND_VALID;
        push_job.desc      = d;
        if (conv_hit) begin
            if (flags_ok && len_ok && wp_ok && desc_ok) begin
                push_job.mask[pfat_pkg::JOB_WSTAR] = ws;
                push_job.mask[pfat_pkg::JOB_PSTAR] = ps;
                push_job.mask[pfat_pkg::JOB_DESC]  = has_desc;
            end else begin
                fail = 1'b1;
            end
        end
        if (s_tlast) begin
            if (ph != PH_PLAIN) begin
                fail = 1'b1;
            end
            push_job.mask[pfat_pkg::JOB_TERM] = 1'b1;
            push_job.term_kind = fail ? pfat_pkg::KIND_INVALID : pfat_pkg::KIND_VALID;
        end
    end

    assign push = accept && (push_job.mask != '0);

    // Parser state; end of string returns everything to reset
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            phase_reg  <= PH_PLAIN;
            flags_reg  <= '0;
            wgiven_reg <= 1'b0;
            wstar_reg  <= 1'b0;
            pgiven_reg <= 1'b0;
            pstar_reg  <= 1'b0;
            len_reg    <= LEN_NONE;
            failed_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= ph;
            flags_reg  <= fl;
            wgiven_reg <= wg;
            wstar_reg  <= ws;
            pgiven_reg <= pg;
            pstar_reg  <= ps;
            len_reg    <= ln;
            failed_reg <= fail;
        end
    end

endmodule

// ===== design/pfat_back.sv =====
// ----------------------------------------------------------------------------
// pfat_back
// Result emitter: unrolls each queued job into its result transfers, one per
// cycle while m_tready allows, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfat_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  pfat_pkg::job_t                head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfat_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    logic [pfat_pkg::JOB_SLOTS-1:0] served_reg, served_next;
    logic [pfat_pkg::JOB_SLOTS-1:0] pending, pick;
    logic                           is_last, load;
    pfat_pkg::desc_t                item;
    pfat_pkg::kind_t                kind;

    logic                           m_tvalid_reg;
    logic [pfat_pkg::TDATA_W-1:0]   m_tdata_reg;
    pfat_pkg::kind_t                m_tuser_reg;
    logic                           m_tlast_reg;

    // Next slot of the head job, lowest first
    assign pending = head.mask & ~served_reg;
    assign pick    = pending & (~pending + 1'b1);
    assign is_last = ((pending & (pending - 1'b1)) == '0);
    assign load    = head_valid && (!m_tvalid_reg || m_tready);
    assign pop     = load && is_last;

    // Select the payload of the picked slot
    always_comb begin
        kind = pfat_pkg::KIND_DESC;
        item = '{cls: pfat_pkg::CLS_INT, vw: pfat_pkg::STAR_WIDTH, pw: 4'd0, sg: 1'b1,
                 unc: 1'b0, heu: 1'b0};
        if (pick[pfat_pkg::JOB_DESC]) begin
            item = head.desc;
        end else if (pick[pfat_pkg::JOB_TERM]) begin
            kind = head.term_kind;
            item = '0;
        end
    end

    always_comb begin
        served_next = served_reg;
        if (load) begin
            served_next = is_last ? '0 : (served_reg | pick);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            served_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            served_reg <= served_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {1'b0, item.heu, item.unc, item.sg, item.pw, item.vw, item.cls};
            m_tuser_reg <= kind;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== design/printf_format_argument_typer.sv =====
// ----------------------------------------------------------------------------
// printf_format_argument_typer
// Types the arguments a printf format string consumes, per target platform.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes the format string one byte per transfer, s_tlast on
//   its final byte. The m_ channel returns one transfer per argument ('*'
//   width, '*' precision, then the conversion), plus a terminal transfer on
//   the final byte whose m_tuser says valid or invalid; m_tlast marks the
//   last result caused by one input byte. After an invalid verdict the
//   consumer drops that string's earlier descriptors.
//   The cfg channel sets pointer size (index 0) and platform family
//   (index 1); write it only while the block is idle. cfg_ready is always 1.
//   Path: a byte's first result passes through the job queue and then the
//   registered output stage before m_tvalid rises.
//   Throughput: one byte per cycle; a byte causing k results holds the
//   emitter until all k have transferred, and a QUEUE_DEPTH-entry job queue
//   lets the parser run ahead until it fills, at which point s_tready drops.
//   Reset: parser returns to plain text, queue empties, pointer size 8,
//   family other. A stalled m_ side holds its transfer and backs up the
//   queue, then the s_ side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module printf_format_argument_typer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Format string input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_char
    input  logic        s_tlast,    // end_of_string
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [2:0] type_class, [7:3] value_width,
                                    // [11:8] pointer_width, [12] is_signed,
                                    // [13] signedness_uncertain,
                                    // [14] type_heuristic, [15] zero
    output logic [1:0]  m_tuser,    // [1:0] item_kind
    output logic        m_tlast,    // last
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    logic [3:0]     addr_size_reg;
    logic [1:0]     family_reg;
    logic           queue_full, push, pop, head_valid;
    pfat_pkg::job_t push_job, head;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_size_reg <= pfat_pkg::ADDR_SIZE_RESET;
            family_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pfat_pkg::CFG_ADDR_SIZE: addr_size_reg <= cfg_data;
                pfat_pkg::CFG_FAMILY:    family_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    pfat_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .addr_size  (addr_size_reg),
        .family     (family_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    pfat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pfat_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== design/pfat_checker.sv =====
// ----------------------------------------------------------------------------
// pfat_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfat_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result transfer holds
    `PFAT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "result changed while stalled")

    // The string verdict is always the final result of its byte
    `PFAT_ASSERT(a_term_last, m_tvalid && (m_tuser != pfat_pkg::KIND_DESC) |-> m_tlast, "verdict without tlast")

    // Verdicts carry an all-zero descriptor
    `PFAT_ASSERT(a_term_zero, m_tvalid && (m_tuser != pfat_pkg::KIND_DESC) |-> (m_tdata == '0), "verdict with payload")

    // Only pointer classes carry a pointer width
    `PFAT_ASSERT(a_pw_class, m_tvalid && (m_tdata[2:0] == pfat_pkg::CLS_INT || m_tdata[2:0] == pfat_pkg::CLS_FLOAT) |-> (m_tdata[11:8] == 4'd0), "pointer width on value class")

endmodule

bind printf_format_argument_typer pfat_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
